// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; clock clk, reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DLL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define DLL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/dll_pkg.sv
// ----------------------------------------------------------------------------
// dll_pkg
// Types, codes and sizes shared by the linked-list block.
// ----------------------------------------------------------------------------
package dll_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 3;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        count_t;
	typedef logic signed [VAL_W-1:0] val_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FIRST = 3'd0,
		CMD_INS_LAST  = 3'd1,
		CMD_INS_AFTER = 3'd2,
		CMD_DEL_FIRST = 3'd3,
		CMD_DEL_LAST  = 3'd4,
		CMD_DEL_VALUE = 3'd5,
		CMD_SEARCH    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_FETCH,
		S_WALK,
		S_W1,
		S_W2,
		S_DONE
	} state_t;

	typedef struct packed {
		val_t value;
		idx_t next;
		idx_t prev;
	} node_t;

	typedef struct packed {
		logic  en_value;
		logic  en_next;
		logic  en_prev;
		idx_t  addr;
		node_t data;
	} ram_wr_t;

	typedef struct packed {
		logic en;
		idx_t addr;
	} ram_rd_t;

	typedef struct packed {
		status_t status;
		val_t    removed;
		count_t  count;
	} result_t;

endpackage

// File: rtl/dll_node_ram.sv
// ----------------------------------------------------------------------------
// dll_node_ram
// Node pool: value, forward and backward link per entry; per-field write
// enables, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dll_node_ram (
	input  logic            clk,
	input  dll_pkg::ram_wr_t wr,
	input  dll_pkg::ram_rd_t rd,
	output dll_pkg::node_t   rd_data
);
	import dll_pkg::*;

	val_t value_mem [CAPACITY];
	idx_t next_mem  [CAPACITY];
	idx_t prev_mem  [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en_value) begin
			value_mem[wr.addr] <= wr.data.value;
		end
		if (wr.en_next) begin
			next_mem[wr.addr] <= wr.data.next;
		end
		if (wr.en_prev) begin
			prev_mem[wr.addr] <= wr.data.prev;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data.value <= value_mem[rd.addr];
			rd_data.next  <= next_mem[rd.addr];
			rd_data.prev  <= prev_mem[rd.addr];
		end
	end

endmodule

// File: rtl/dll_ctrl.sv
// ----------------------------------------------------------------------------
// dll_ctrl
// Command sequencer: head, tail, count and free map; walks the list one
// node read per cycle and relinks through the node pool write port.
// ----------------------------------------------------------------------------
module dll_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dll_pkg::cmd_t     cmd_in,
	input  dll_pkg::val_t     item_in,
	input  dll_pkg::val_t     key_in,
	output logic              res_valid,
	input  logic              res_ready,
	output dll_pkg::result_t  res,
	output dll_pkg::ram_wr_t  ram_wr,
	output dll_pkg::ram_rd_t  ram_rd,
	input  dll_pkg::node_t    rd_data
);
	import dll_pkg::*;

	state_t              state_q, state_d;
	logic [CAPACITY-1:0] free_q;
	idx_t                free_idx_q, lowest;
	idx_t                head_q, tail_q, cur_q;
	count_t              count_q, k_q;
	cmd_t                cmd_q;
	val_t                item_q, key_q, target_q, removed_q;
	status_t             status_q, status_d;
	ram_wr_t             lk1_q, lk2_q, lk1_d, lk2_d;

	logic empty, full, walk_hit, walk_last, drop_head, drop_tail, link_one;
	logic do_put_first, do_put_last, do_put_after, do_drop, do_put;
	logic done_now, start_walk, start_fetch, walk_step;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign walk_hit  = (rd_data.value == target_q);
	assign walk_last = ((k_q + count_t'(1)) == count_q);
	assign drop_head = (cur_q == head_q);
	assign drop_tail = (cur_q == tail_q);
	assign do_put    = do_put_first | do_put_last | do_put_after;

	// lowest free entry, registered
	always_comb begin
		lowest = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				lowest = idx_t'(i);
			end
		end
	end

	always_comb begin
		do_put_first = 1'b0;
		do_put_last  = 1'b0;
		do_put_after = 1'b0;
		do_drop      = 1'b0;
		done_now     = 1'b0;
		start_walk   = 1'b0;
		start_fetch  = 1'b0;
		walk_step    = 1'b0;
		status_d     = ST_OK;
		case (state_q)
			S_DISPATCH: begin
				case (cmd_q)
					CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AFTER: begin
						if (full) begin
							status_d = ST_FULL;
							done_now = 1'b1;
						end else if (cmd_q == CMD_INS_FIRST) begin
							do_put_first = 1'b1;
						end else if (cmd_q == CMD_INS_LAST || empty) begin
							do_put_last = 1'b1;
						end else begin
							start_walk = 1'b1;
						end
					end
					CMD_DEL_FIRST, CMD_DEL_LAST: begin
						if (empty) begin
							status_d = ST_EMPTY;
							done_now = 1'b1;
						end else begin
							start_fetch = 1'b1;
						end
					end
					CMD_DEL_VALUE, CMD_SEARCH: begin
						if (empty) begin
							status_d = ST_EMPTY;
							done_now = 1'b1;
						end else begin
							start_walk = 1'b1;
						end
					end
					default: begin
						done_now = 1'b1;
					end
				endcase
			end
			S_FETCH: begin
				do_drop = 1'b1;
			end
			S_WALK: begin
				if (walk_hit) begin
					case (cmd_q)
						CMD_INS_AFTER: begin
							if (drop_tail) begin
								do_put_last = 1'b1;
							end else begin
								do_put_after = 1'b1;
							end
						end
						CMD_DEL_VALUE: begin
							do_drop = 1'b1;
						end
						default: begin
							done_now = 1'b1;
						end
					endcase
				end else if (walk_last) begin
					if (cmd_q == CMD_INS_AFTER) begin
						do_put_last = 1'b1;
					end else begin
						status_d = ST_NOT_FOUND;
						done_now = 1'b1;
					end
				end else begin
					walk_step = 1'b1;
				end
			end
			default: ;
		endcase
		link_one = ((do_put_first || do_put_last) && !empty) || do_put_after ||
			(do_drop && !drop_head && !drop_tail);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH, S_FETCH, S_WALK: begin
				if (link_one) begin
					state_d = S_W1;
				end else if (do_put || do_drop || done_now) begin
					state_d = S_DONE;
				end else if (start_walk) begin
					state_d = S_WALK;
				end else if (start_fetch) begin
					state_d = S_FETCH;
				end
			end
			S_W1: begin
				state_d = (lk2_q.en_next || lk2_q.en_prev) ? S_W2 : S_DONE;
			end
			S_W2: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		res_valid = (state_q == S_DONE);
		res       = '{status: status_q, removed: removed_q, count: count_q};

		ram_rd.en   = start_walk | start_fetch | walk_step;
		ram_rd.addr = head_q;
		if (start_fetch && cmd_q == CMD_DEL_LAST) begin
			ram_rd.addr = tail_q;
		end else if (walk_step) begin
			ram_rd.addr = rd_data.next;
		end

		ram_wr = '0;
		case (state_q)
			S_W1: ram_wr = lk1_q;
			S_W2: ram_wr = lk2_q;
			default: begin
				if (do_put) begin
					ram_wr.en_value   = 1'b1;
					ram_wr.en_next    = 1'b1;
					ram_wr.en_prev    = 1'b1;
					ram_wr.addr       = free_idx_q;
					ram_wr.data.value = item_q;
					if (do_put_first) begin
						ram_wr.data.next = empty ? '0 : head_q;
					end else if (do_put_last) begin
						ram_wr.data.prev = empty ? '0 : tail_q;
					end else begin
						ram_wr.data.next = rd_data.next;
						ram_wr.data.prev = cur_q;
					end
				end
			end
		endcase
	end

	// neighbor link writes for the following cycles
	always_comb begin
		lk1_d = '0;
		lk2_d = '0;
		if (do_put_first) begin
			lk1_d.en_prev   = 1'b1;
			lk1_d.addr      = head_q;
			lk1_d.data.prev = free_idx_q;
		end
		if (do_put_last) begin
			lk1_d.en_next   = 1'b1;
			lk1_d.addr      = tail_q;
			lk1_d.data.next = free_idx_q;
		end
		if (do_put_after) begin
			lk1_d.en_next   = 1'b1;
			lk1_d.addr      = cur_q;
			lk1_d.data.next = free_idx_q;
			lk2_d.en_prev   = 1'b1;
			lk2_d.addr      = rd_data.next;
			lk2_d.data.prev = free_idx_q;
		end
		if (do_drop && !drop_head && !drop_tail) begin
			lk1_d.en_next   = 1'b1;
			lk1_d.addr      = rd_data.prev;
			lk1_d.data.next = rd_data.next;
			lk2_d.en_prev   = 1'b1;
			lk2_d.addr      = rd_data.next;
			lk2_d.data.prev = rd_data.prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			free_q     <= '1;
			free_idx_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
		end else begin
			state_q    <= state_d;
			free_idx_q <= lowest;
			if (do_put) begin
				free_q[free_idx_q] <= 1'b0;
				count_q            <= count_q + count_t'(1);
			end
			if (do_put_first) begin
				head_q <= free_idx_q;
				if (empty) begin
					tail_q <= free_idx_q;
				end
			end
			if (do_put_last) begin
				tail_q <= free_idx_q;
				if (empty) begin
					head_q <= free_idx_q;
				end
			end
			if (do_drop) begin
				free_q[cur_q] <= 1'b1;
				count_q       <= count_q - count_t'(1);
				if (drop_head && drop_tail) begin
					head_q <= '0;
					tail_q <= '0;
				end else if (drop_head) begin
					head_q <= rd_data.next;
				end else if (drop_tail) begin
					tail_q <= rd_data.prev;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q     <= cmd_in;
			item_q    <= item_in;
			key_q     <= key_in;
			removed_q <= '0;
			status_q  <= ST_OK;
		end
		if (done_now) begin
			status_q <= status_d;
		end
		if (start_walk) begin
			cur_q    <= head_q;
			k_q      <= '0;
			target_q <= (cmd_q == CMD_INS_AFTER) ? key_q : item_q;
		end
		if (start_fetch) begin
			cur_q <= ram_rd.addr;
		end
		if (walk_step) begin
			cur_q <= rd_data.next;
			k_q   <= k_q + count_t'(1);
		end
		if (state_q == S_FETCH) begin
			removed_q <= rd_data.value;
		end
		if (do_put || do_drop) begin
			lk1_q <= lk1_d;
			lk2_q <= lk2_d;
		end
	end

endmodule

// File: rtl/bounded_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list
// Ordered list of signed values in a pool of CAPACITY linked nodes.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    cmd, item_value, anchor_key
//   out      out  out_valid/out_stall  status, removed_value, entry_count
//
// One item at a time. Insert first/last and the empty, full and unused-code
// cases finish without reading a node; delete first/last read one node; a key
// or value search reads one node per cycle from the node pool, up to entry_count.
// Reset clears the free map, head, tail and count at once; no clearing pass.
// A result waits in the output register while the next item is taken; a
// stalled output holds the next result, and so the input, until it drains.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [dll_pkg::CMD_W-1:0]        cmd,
	input  logic signed [dll_pkg::VAL_W-1:0] item_value,
	input  logic signed [dll_pkg::VAL_W-1:0] anchor_key,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic signed [dll_pkg::VAL_W-1:0] removed_value,
	output logic [dll_pkg::CNT_W-1:0]        entry_count
);
	import dll_pkg::*;

	ram_wr_t ram_wr;
	ram_rd_t ram_rd;
	node_t   rd_data;
	result_t res, result_q;
	logic    res_valid, res_ready, out_valid_q;

	assign res_ready = !out_valid_q || !out_stall;

	dll_node_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (rd_data)
	);

	dll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd_in    (cmd_t'(cmd)),
		.item_in   (item_value),
		.key_in    (anchor_key),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_wr    (ram_wr),
		.ram_rd    (ram_rd),
		.rd_data   (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			result_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = result_q.status;
	assign removed_value = result_q.removed;
	assign entry_count   = result_q.count;

endmodule

// File: rtl/dll_checker.sv
// ----------------------------------------------------------------------------
// dll_checker
// Port-level checks for the linked-list block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dll_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [1:0]                status,
	input logic [dll_pkg::CNT_W-1:0] entry_count
);
	import dll_pkg::*;

	`DLL_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`DLL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(entry_count))
	`DLL_ASSERT_NOW(a_count_bound, out_valid, entry_count <= CNT_W'(CAPACITY))
	`DLL_ASSERT_NOW(a_full_count, out_valid && status == ST_FULL, entry_count == CNT_W'(CAPACITY))
	`DLL_ASSERT_NOW(a_empty_count, out_valid && status == ST_EMPTY, entry_count == '0)

endmodule

bind bounded_doubly_linked_list dll_checker u_dll_checker (.*);

// File: test/bounded_doubly_linked_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_tb
// Drives random and directed list commands through the valid/stall ports,
// keeps a queue-based copy of the list to predict status, removed value and
// count, and compares every result in order. Idle and stall rates change by
// phase, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list_tb;
	import dll_pkg::*;

	typedef struct packed {
		status_t status;
		val_t    removed;
		count_t  count;
	} list_result_t;

	class list_scoreboard;
		val_t         contents[$];
		list_result_t pending[$];
		int           errors;
		int           checked;

		function int find_first(val_t v);
			foreach (contents[i])
				if (contents[i] == v)
					return i;
			return -1;
		endfunction

		function void note_command(logic [2:0] c, val_t v, val_t k);
			list_result_t r;
			int           pos;
			r.status  = ST_OK;
			r.removed = '0;
			case (c)
				CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AFTER: begin
					if (contents.size() >= CAPACITY)
						r.status = ST_FULL;
					else if (c == CMD_INS_FIRST)
						contents.push_front(v);
					else if (c == CMD_INS_LAST)
						contents.push_back(v);
					else begin
						pos = find_first(k);
						if (pos < 0)
							contents.push_back(v);
						else
							contents.insert(pos + 1, v);
					end
				end
				CMD_DEL_FIRST, CMD_DEL_LAST: begin
					if (contents.size() == 0)
						r.status = ST_EMPTY;
					else if (c == CMD_DEL_FIRST)
						r.removed = contents.pop_front();
					else
						r.removed = contents.pop_back();
				end
				CMD_DEL_VALUE, CMD_SEARCH: begin
					pos = find_first(v);
					if (contents.size() == 0)
						r.status = ST_EMPTY;
					else if (pos < 0)
						r.status = ST_NOT_FOUND;
					else if (c == CMD_DEL_VALUE)
						contents.delete(pos);
				end
				default: ;
			endcase
			r.count = count_t'(contents.size());
			pending.push_back(r);
		endfunction

		task automatic report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		endtask

		task automatic check_result(logic [1:0] s, val_t rv, count_t n);
			list_result_t e;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected result", 64'({s, rv, n}), 64'(0));
				return;
			end
			e = pending.pop_front();
			if (s != e.status)
				report("status", 64'(s), 64'(e.status));
			if (rv != e.removed)
				report("removed_value", 64'(rv), 64'(e.removed));
			if (n != e.count)
				report("entry_count", 64'(n), 64'(e.count));
		endtask
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	logic [2:0] cmd = '0;
	val_t       item_value = '0;
	val_t       anchor_key = '0;
	logic       out_valid;
	logic       out_stall = 0;
	logic [1:0] status;
	val_t       removed_value;
	count_t     entry_count;

	list_scoreboard board = new();
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   long_hold;
	event hold_start;

	bounded_doubly_linked_list dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk)
		if (out_valid && !out_stall)
			board.check_result(status, removed_value, entry_count);

	// long receiver hold-off, counted in cycles
	initial begin
		long_hold = 0;
		@(hold_start);
		long_hold = 1;
		repeat (150) @(posedge clk);
		long_hold = 0;
	end

	always @(negedge clk)
		out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);

	function automatic val_t pick_value();
		val_t v;
		if (board.contents.size() > 0 && $urandom_range(99) < 60)
			v = board.contents[$urandom_range(board.contents.size() - 1)];
		else if ($urandom_range(3) == 0)
			v = $urandom;
		else
			v = val_t'($urandom_range(15)) - 8;
		return v;
	endfunction

	task automatic send_command(logic [2:0] c, val_t v, val_t k);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		cmd        <= c;
		item_value <= v;
		anchor_key <= k;
		in_valid   <= 1;
		do
			@(posedge clk);
		while (in_stall);
		board.note_command(c, v, k);
		@(negedge clk);
	endtask

	task automatic send_random();
		int         r;
		logic [2:0] c;
		r = $urandom_range(99);
		if (board.contents.size() < 40)
			c = (r < 55) ? 3'($urandom_range(2)) : 3'($urandom_range(7));
		else
			c = (r < 30) ? 3'($urandom_range(2)) : 3'($urandom_range(7));
		send_command(c, pick_value(), pick_value());
	endtask

	initial begin
		#10000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_command(CMD_DEL_FIRST, 0, 0);
		send_command(CMD_DEL_LAST, 0, 0);
		send_command(CMD_SEARCH, 5, 0);
		send_command(CMD_DEL_VALUE, 5, 0);
		send_command(CMD_INS_AFTER, 32'sh7fffffff, 1);
		send_command(CMD_DEL_LAST, 0, 0);
		send_command(CMD_INS_FIRST, 32'sh80000000, 0);
		send_command(CMD_INS_LAST, -1, 0);
		send_command(CMD_INS_AFTER, 7, 32'sh80000000);
		send_command(CMD_INS_AFTER, 9, 12345);
		send_command(CMD_INS_AFTER, 3, 9);
		send_command(CMD_SEARCH, 7, 0);
		send_command(CMD_SEARCH, 100, 0);
		send_command(CMD_DEL_VALUE, 100, 0);
		send_command(CMD_DEL_VALUE, 7, 0);
		send_command(3'd7, 1, 1);
		send_command(CMD_DEL_FIRST, 0, 0);
		send_command(CMD_DEL_LAST, 0, 0);

		// fill the pool to overflow, starting under a long receiver hold-off
		-> hold_start;
		while (board.contents.size() < CAPACITY)
			send_command(3'($urandom_range(2)), $urandom, $urandom);
		send_command(CMD_INS_LAST, 1, 0);
		send_command(CMD_INS_AFTER, 2, 0);
		send_command(CMD_SEARCH, board.contents[CAPACITY-1], 0);
		send_command(CMD_DEL_LAST, 0, 0);

		send_idle_pct = 21;
		recv_stall_pct = 65;
		repeat (140) send_random();
		send_idle_pct = 65;
		recv_stall_pct = 21;
		repeat (140) send_random();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (140) send_random();
		in_valid <= 0;

		while (board.pending.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d results, pool overflow, empty and not-found cases",
			board.checked);
		$display("final list length %0d, %0d mismatches", board.contents.size(),
			board.errors);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
